// File: hw/rtl/tsop_pkg.sv
// ----------------------------------------------------------------------------
// TCP SYN option parser package
// Shared types and constants: option kinds, expected lengths, walk phases
// and the beat structures that pass between the stages.
// ----------------------------------------------------------------------------
package tsop_pkg;

  // Option kinds
  localparam logic [7:0] KIND_EOL  = 8'd0;
  localparam logic [7:0] KIND_NOP  = 8'd1;
  localparam logic [7:0] KIND_MSS  = 8'd2;
  localparam logic [7:0] KIND_WS   = 8'd3;
  localparam logic [7:0] KIND_TS   = 8'd8;

  // Minimum and exact option lengths, kind and length bytes included
  localparam logic [7:0] LEN_MIN   = 8'd2;
  localparam logic [7:0] LEN_MSS   = 8'd4;
  localparam logic [7:0] LEN_WS    = 8'd3;
  localparam logic [7:0] LEN_TS    = 8'd10;

  // Walk phase through kind, length and body
  typedef enum logic [1:0] {
    PH_KIND = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2,
    PH_STOP = 2'd3
  } phase_e;

  // One input beat
  typedef struct packed {
    logic [7:0] opt_byte;
    logic       last_byte;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    logic [15:0] mss_value;
    logic [7:0]  window_shift;
    logic [31:0] ts_value;
    logic [31:0] ts_echo;
    logic        malformed;
  } res_beat_t;

endpackage

// File: hw/rtl/tsop_in_if.sv
// ----------------------------------------------------------------------------
// Option byte channel
// Valid/ready channel that carries one option byte and its last marker.
// ----------------------------------------------------------------------------
interface tsop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opt_byte;
  logic       last_byte;

  modport source (output valid, output opt_byte, output last_byte, input ready);
  modport sink   (input valid, input opt_byte, input last_byte, output ready);
endinterface

// File: hw/rtl/tsop_out_if.sv
// ----------------------------------------------------------------------------
// Parse result channel
// Valid/ready channel that carries the options picked out of one option area.
// ----------------------------------------------------------------------------
interface tsop_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] mss_value;
  logic [7:0]  window_shift;
  logic [31:0] ts_value;
  logic [31:0] ts_echo;
  logic        malformed;

  modport source (output valid, output mss_value, output window_shift, output ts_value,
                  output ts_echo, output malformed, input ready);
  modport sink   (input valid, input mss_value, input window_shift, input ts_value,
                  input ts_echo, input malformed, output ready);
endinterface

// File: hw/rtl/tsop_in_stage.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one option byte beat until the walk stage consumes it.
// ----------------------------------------------------------------------------
module tsop_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  tsop_in_if.sink            in_i,
  input  logic               advance_i,
  output logic               valid_o,
  output tsop_pkg::in_beat_t beat_o
);

  logic               valid_q;
  tsop_pkg::in_beat_t beat_q;
  logic               load;

  // Take a new beat when empty or when the held beat moves on
  assign in_i.ready = !valid_q || advance_i;
  assign load       = in_i.valid && in_i.ready;

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q.opt_byte  <= in_i.opt_byte;
      beat_q.last_byte <= in_i.last_byte;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// File: hw/rtl/tsop_walk.sv
// ----------------------------------------------------------------------------
// Option walker
// Steps through kind, length and body one byte per cycle unless a closing byte
// waits for room, keeps picked out options, emits them at the area's last byte
module tsop_walk (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  tsop_pkg::in_beat_t  beat_i,
  input  logic                out_free_i,
  output logic                advance_o,
  output logic                res_valid_o,
  output tsop_pkg::res_beat_t res_o
);

  tsop_pkg::phase_e phase_q, phase_d;
  logic [7:0]       kind_q, kind_d;
  logic [7:0]       left_q, left_d;
  logic [63:0]      shift_q, shift_d;
  logic             match_q, match_d;
  logic [15:0]      mss_q, mss_d;
  logic [7:0]       ws_q, ws_d;
  logic [31:0]      tsv_q, tsv_d;
  logic [31:0]      tse_q, tse_d;
  logic             bad_q, bad_d;
  logic             done;
  logic [7:0]       b;

  assign b = beat_i.opt_byte;

  // Hold a closing beat until the result register has room
  assign advance_o   = valid_i && (!beat_i.last_byte || out_free_i);
  assign res_valid_o = advance_o && beat_i.last_byte;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      tsop_pkg::PH_KIND: begin
        if (b == tsop_pkg::KIND_EOL) begin
          phase_d = tsop_pkg::PH_STOP;
        end else if (b != tsop_pkg::KIND_NOP) begin
          phase_d = tsop_pkg::PH_LEN;
        end
      end
      tsop_pkg::PH_LEN: begin
        if (b < tsop_pkg::LEN_MIN) begin
          phase_d = tsop_pkg::PH_STOP;
        end else if (b == tsop_pkg::LEN_MIN) begin
          phase_d = tsop_pkg::PH_KIND;
        end else begin
          phase_d = tsop_pkg::PH_BODY;
        end
      end
      tsop_pkg::PH_BODY: begin
        if (left_q == 8'd1) begin
          phase_d = tsop_pkg::PH_KIND;
        end
      end
      default: phase_d = phase_q;
    endcase
  end

  // Option datapath: kind, body count, body shifter and error flag
  always_comb begin
    kind_d  = kind_q;
    left_d  = left_q;
    shift_d = shift_q;
    match_d = match_q;
    bad_d   = bad_q;
    done    = 1'b0;
    case (phase_q)
      tsop_pkg::PH_KIND: begin
        if (b != tsop_pkg::KIND_EOL && b != tsop_pkg::KIND_NOP) begin
          kind_d = b;
        end
      end
      tsop_pkg::PH_LEN: begin
        if (b < tsop_pkg::LEN_MIN) begin
          bad_d = 1'b1;
        end else begin
          match_d = (kind_q == tsop_pkg::KIND_MSS && b == tsop_pkg::LEN_MSS) ||
                    (kind_q == tsop_pkg::KIND_WS  && b == tsop_pkg::LEN_WS)  ||
                    (kind_q == tsop_pkg::KIND_TS  && b == tsop_pkg::LEN_TS);
          left_d  = b - tsop_pkg::LEN_MIN;
          shift_d = '0;
          done    = (b == tsop_pkg::LEN_MIN);
        end
      end
      tsop_pkg::PH_BODY: begin
        shift_d = {shift_q[55:0], b};
        left_d  = left_q - 8'd1;
        done    = (left_q == 8'd1);
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  // Commit a complete option whose kind and length match
  always_comb begin
    mss_d = mss_q;
    ws_d  = ws_q;
    tsv_d = tsv_q;
    tse_d = tse_q;
    if (done && match_d) begin
      case (kind_q)
        tsop_pkg::KIND_MSS: mss_d = shift_d[15:0];
        tsop_pkg::KIND_WS:  ws_d  = shift_d[7:0];
        tsop_pkg::KIND_TS: begin
          tsv_d = shift_d[63:32];
          tse_d = shift_d[31:0];
        end
        default: mss_d = mss_q;
      endcase
    end
  end

  // Result seen at the closing byte
  always_comb begin
    res_o.mss_value    = mss_d;
    res_o.window_shift = ws_d;
    res_o.ts_value     = tsv_d;
    res_o.ts_echo      = tse_d;
    res_o.malformed    = bad_d;
  end

  // Advance state; clear it after the closing byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tsop_pkg::PH_KIND;
      kind_q  <= '0;
      left_q  <= '0;
      shift_q <= '0;
      match_q <= 1'b0;
      mss_q   <= '0;
      ws_q    <= '0;
      tsv_q   <= '0;
      tse_q   <= '0;
      bad_q   <= 1'b0;
    end else if (advance_o) begin
      if (beat_i.last_byte) begin
        phase_q <= tsop_pkg::PH_KIND;
        kind_q  <= '0;
        left_q  <= '0;
        shift_q <= '0;
        match_q <= 1'b0;
        mss_q   <= '0;
        ws_q    <= '0;
        tsv_q   <= '0;
        tse_q   <= '0;
        bad_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        kind_q  <= kind_d;
        left_q  <= left_d;
        shift_q <= shift_d;
        match_q <= match_d;
        mss_q   <= mss_d;
        ws_q    <= ws_d;
        tsv_q   <= tsv_d;
        tse_q   <= tse_d;
        bad_q   <= bad_d;
      end
    end
  end

endmodule

// File: hw/rtl/tsop_out_stage.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module tsop_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  input  tsop_pkg::res_beat_t res_i,
  output logic                out_free_o,
  tsop_out_if.source          out_o
);

  logic                valid_q;
  tsop_pkg::res_beat_t res_q;

  // Room when empty or when the held beat leaves this cycle
  assign out_free_o = !valid_q || out_o.ready;

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_free_o) begin
      valid_q <= res_valid_i;
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (res_valid_i && out_free_o) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.mss_value    = res_q.mss_value;
  assign out_o.window_shift = res_q.window_shift;
  assign out_o.ts_value     = res_q.ts_value;
  assign out_o.ts_echo      = res_q.ts_echo;
  assign out_o.malformed    = res_q.malformed;

endmodule

// File: hw/rtl/tcp_syn_option_parser_top.sv
// ----------------------------------------------------------------------------
// TCP SYN option parser
// Walks the option area of a SYN header and reports MSS, window scale and
// timestamp options plus a malformed flag at the last byte.
// ----------------------------------------------------------------------------
// The block takes one option byte per cycle on in_i, sustained, with no gaps
// needed between option areas. Each byte passes an input register, the
// combinational kind/length/body decoding, and a result register, so the
// result for an area reaches out_o through both registers after its last byte.
// Only the last byte of an area waits on out_o: while the result register
// is full and not taken, that byte is held and in_i stalls behind it. All
// walk state clears after each last byte, so areas are independent.
module tcp_syn_option_parser_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsop_in_if.sink    in_i,
  tsop_out_if.source out_o
);

  logic                advance;
  logic                stage_valid;
  tsop_pkg::in_beat_t  stage_beat;
  logic                res_valid;
  tsop_pkg::res_beat_t res;
  logic                out_free;

  tsop_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (stage_valid),
    .beat_o    (stage_beat)
  );

  tsop_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage_valid),
    .beat_i      (stage_beat),
    .out_free_i  (out_free),
    .advance_o   (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tsop_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_free_o  (out_free),
    .out_o       (out_o)
  );

endmodule

// File: bench/tcp_syn_option_parser_top_test.sv
// ----------------------------------------------------------------------------
// TCP SYN option parser testbench
// Streams directed and random option areas into the parser through a
// valid/ready driver with random gaps, predicts the MSS, window scale,
// timestamp and malformed result of every area, and compares each result
// beat taken from the output channel against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tcp_syn_option_parser_top_test;

  localparam int LIMIT_CYCLES = 200000;
  localparam int IDLE_PCT     = 32;
  localparam int QUIET_FROM   = 400;
  localparam int QUIET_TO     = 1000;
  localparam int TAIL_CYCLES  = 16;
  localparam int RANDOM_BYTES = 400;
  localparam int RANDOM_AREAS = 40;

  // One queued byte; wait_drain holds it until every pending result has arrived
  typedef struct {
    tsop_pkg::in_beat_t beat;
    bit                 wait_drain;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tsop_in_if  in_if ();
  tsop_out_if out_if ();

  tcp_syn_option_parser_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  stim_t               byte_queue[$];
  tsop_pkg::res_beat_t results_due[$];
  logic [7:0]          area_bytes[$];
  int                  cycle_count = 0;
  int                  error_count = 0;

  // Option walk state of the predictor
  tsop_pkg::phase_e    walk_phase;
  logic [7:0]          walk_kind;
  logic [7:0]          body_count;
  logic [63:0]         body_window;
  logic                len_exact;
  tsop_pkg::res_beat_t held_opts;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Random gap decision, switched off during the quiet stretch
  function automatic bit take_break();
    return (cycle_count < QUIET_FROM || cycle_count >= QUIET_TO) &&
           ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  task automatic clear_walk();
    walk_phase  = tsop_pkg::PH_KIND;
    walk_kind   = '0;
    body_count  = '0;
    body_window = '0;
    len_exact   = 1'b0;
    held_opts   = '0;
  endtask

  // Keep a finished option only when kind and length match exactly
  task automatic commit_option();
    if (len_exact) begin
      case (walk_kind)
        tsop_pkg::KIND_MSS: held_opts.mss_value = body_window[15:0];
        tsop_pkg::KIND_WS:  held_opts.window_shift = body_window[7:0];
        tsop_pkg::KIND_TS: begin
          held_opts.ts_value = body_window[63:32];
          held_opts.ts_echo  = body_window[31:0];
        end
        default: ;
      endcase
    end
  endtask

  // Advance the walk by one accepted byte; queue a result at the last byte
  task automatic predict_options(input tsop_pkg::in_beat_t beat);
    case (walk_phase)
      tsop_pkg::PH_KIND: begin
        if (beat.opt_byte == tsop_pkg::KIND_EOL) begin
          walk_phase = tsop_pkg::PH_STOP;
        end else if (beat.opt_byte != tsop_pkg::KIND_NOP) begin
          walk_kind  = beat.opt_byte;
          walk_phase = tsop_pkg::PH_LEN;
        end
      end
      tsop_pkg::PH_LEN: begin
        if (beat.opt_byte < tsop_pkg::LEN_MIN) begin
          held_opts.malformed = 1'b1;
          walk_phase = tsop_pkg::PH_STOP;
        end else begin
          len_exact = (walk_kind == tsop_pkg::KIND_MSS && beat.opt_byte == tsop_pkg::LEN_MSS) ||
                      (walk_kind == tsop_pkg::KIND_WS  && beat.opt_byte == tsop_pkg::LEN_WS)  ||
                      (walk_kind == tsop_pkg::KIND_TS  && beat.opt_byte == tsop_pkg::LEN_TS);
          body_count  = beat.opt_byte - tsop_pkg::LEN_MIN;
          body_window = '0;
          if (body_count == 8'd0) begin
            commit_option();
            walk_phase = tsop_pkg::PH_KIND;
          end else begin
            walk_phase = tsop_pkg::PH_BODY;
          end
        end
      end
      tsop_pkg::PH_BODY: begin
        body_window = {body_window[55:0], beat.opt_byte};
        body_count  = body_count - 8'd1;
        if (body_count == 8'd0) begin
          commit_option();
          walk_phase = tsop_pkg::PH_KIND;
        end
      end
      default: ;
    endcase
    if (beat.last_byte) begin
      results_due.push_back(held_opts);
      clear_walk();
    end
  endtask

  task automatic add_random(input int count);
    repeat (count) area_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_option(input logic [7:0] kind, input int len);
    area_bytes.push_back(kind);
    area_bytes.push_back(8'(len));
    add_random(len - 2);
  endtask

  // Append one complete option of a random sort
  task automatic add_any_option();
    logic [7:0] kind;
    int         len;
    case ($urandom_range(0, 7))
      0: area_bytes.push_back(tsop_pkg::KIND_NOP);
      1: add_option(tsop_pkg::KIND_MSS, int'(tsop_pkg::LEN_MSS));
      2: add_option(tsop_pkg::KIND_WS, int'(tsop_pkg::LEN_WS));
      3, 4: add_option(tsop_pkg::KIND_TS, int'(tsop_pkg::LEN_TS));
      5: begin
        // random kind from 4 up, timestamp included, now and then with a very long body
        kind = 8'($urandom_range(4, 255));
        len  = ($urandom_range(0, 49) == 0) ? int'($urandom_range(2, 255)) :
                                              int'($urandom_range(2, 12));
        add_option(kind, len);
      end
      6: begin
        // known kind with a length that is usually wrong
        case ($urandom_range(0, 2))
          0:       kind = tsop_pkg::KIND_MSS;
          1:       kind = tsop_pkg::KIND_WS;
          default: kind = tsop_pkg::KIND_TS;
        endcase
        add_option(kind, int'($urandom_range(2, 14)));
      end
      default: add_option(8'd4, int'(tsop_pkg::LEN_MIN));
    endcase
  endtask

  // Build one random option area in area_bytes
  task automatic build_random_area();
    int pick;
    int cut;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      repeat ($urandom_range(1, 6)) add_any_option();
      if ($urandom_range(0, 4) == 0) begin
        area_bytes.push_back(tsop_pkg::KIND_EOL);
        add_random($urandom_range(0, 5));
      end
      // truncate at a random point, which may cut the final option short
      if ($urandom_range(0, 9) == 0 && area_bytes.size() > 1) begin
        cut = $urandom_range(1, area_bytes.size() - 1);
        repeat (cut) void'(area_bytes.pop_back());
      end
    end else if (pick < 82) begin
      repeat ($urandom_range(0, 2)) add_any_option();
      area_bytes.push_back(8'($urandom_range(2, 255)));
      area_bytes.push_back(8'($urandom_range(0, 1)));
      add_random($urandom_range(0, 5));
    end else begin
      add_random($urandom_range(1, 24));
    end
  endtask

  // Move area_bytes into the byte queue, marking the final byte as last
  task automatic flush_area(input bit drain);
    stim_t s;
    for (int i = 0; i < area_bytes.size(); i++) begin
      s.beat.opt_byte  = area_bytes[i];
      s.beat.last_byte = (i == area_bytes.size() - 1);
      s.wait_drain     = drain && (i == 0);
      byte_queue.push_back(s);
    end
    area_bytes.delete();
  endtask

  // Driver: present queued bytes, predict from each beat taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.opt_byte  <= '0;
      in_if.last_byte <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_options({in_if.opt_byte, in_if.last_byte});
      end
      if (!in_if.valid || in_if.ready) begin
        if (byte_queue.size() != 0 &&
            !(byte_queue[0].wait_drain && results_due.size() != 0) &&
            !take_break()) begin
          in_if.valid     <= 1'b1;
          in_if.opt_byte  <= byte_queue[0].beat.opt_byte;
          in_if.last_byte <= byte_queue[0].beat.last_byte;
          void'(byte_queue.pop_front());
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, compare each result beat with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    tsop_pkg::res_beat_t want;
    tsop_pkg::res_beat_t got;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= !take_break();
      if (out_if.valid && out_if.ready) begin
        got = {out_if.mss_value, out_if.window_shift, out_if.ts_value,
               out_if.ts_echo, out_if.malformed};
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h", $time, got);
          error_count++;
        end else begin
          want = results_due.pop_front();
          if (want !== got) begin
            $display("%0t: result mismatch, expected mss %h ws %h tsval %h tsecr %h bad %b",
                     $time, want.mss_value, want.window_shift, want.ts_value,
                     want.ts_echo, want.malformed);
            $display("%0t:                  actual mss %h ws %h tsval %h tsecr %h bad %b",
                     $time, got.mss_value, got.window_shift, got.ts_value,
                     got.ts_echo, got.malformed);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int random_bytes;
    int random_areas;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.opt_byte  = '0;
    in_if.last_byte = 1'b0;
    out_if.ready    = 1'b0;
    clear_walk();
    random_bytes = 0;
    random_areas = 0;

    // end of list, trailing byte ignored
    area_bytes = '{8'h00, 8'hFF};
    flush_area(1'b0);
    // MSS completing exactly on the last byte, all ones
    area_bytes = '{tsop_pkg::KIND_MSS, tsop_pkg::LEN_MSS, 8'hFF, 8'hFF};
    flush_area(1'b0);
    // no-op, window scale, timestamp ending on the last byte
    area_bytes = '{tsop_pkg::KIND_NOP, tsop_pkg::KIND_WS, tsop_pkg::LEN_WS, 8'h0E,
                   tsop_pkg::KIND_TS, tsop_pkg::LEN_TS,
                   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
    flush_area(1'b0);
    // length one stops parsing, later byte ignored; wait for results first
    area_bytes = '{tsop_pkg::KIND_MSS, 8'h01, 8'hFF};
    flush_area(1'b1);
    // length zero on the last byte
    area_bytes = '{8'h05, 8'h00};
    flush_area(1'b0);
    // MSS cut short by the last byte
    area_bytes = '{tsop_pkg::KIND_MSS, tsop_pkg::LEN_MSS, 8'h05};
    flush_area(1'b0);

    while (random_bytes < RANDOM_BYTES || random_areas < RANDOM_AREAS) begin
      build_random_area();
      random_bytes += area_bytes.size();
      random_areas++;
      flush_area($urandom_range(0, 9) == 0 || random_areas == 20);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain stimulus and results, then let the pipeline settle
    while (byte_queue.size() != 0 || in_if.valid || results_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (error_count == 0 && results_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/tsop_pkg.sv
hw/rtl/tsop_in_if.sv
hw/rtl/tsop_out_if.sv
hw/rtl/tsop_in_stage.sv
hw/rtl/tsop_walk.sv
hw/rtl/tsop_out_stage.sv
hw/rtl/tcp_syn_option_parser_top.sv
bench/tcp_syn_option_parser_top_test.sv
